/* rtl/tdp_pkg.sv */
`timescale 1ns / 1ps

package tdp_pkg;

  // Width of the candidate field
  localparam int VALUE_BITS = 31;
  // Counter width for the bit-serial divider (counts 0 .. VALUE_BITS-1)
  localparam int CNT_W = $clog2(VALUE_BITS);

  // Program steps; the step counter is the microprogram address
  typedef enum logic [3:0] {
    STEP_WAIT    = 4'd0,
    STEP_SMALL   = 4'd1,
    STEP_DIVINIT = 4'd2,
    STEP_DIVSTEP = 4'd3,
    STEP_TEST_Q  = 4'd4,
    STEP_TEST_R  = 4'd5,
    STEP_NEXT    = 4'd6,
    STEP_PRIME   = 4'd7,
    STEP_EMIT    = 4'd8,
    STEP_DONE    = 4'd9
  } step_t;

  // Datapath action of one control word
  typedef enum logic [2:0] {
    ACT_NOP      = 3'd0,
    ACT_LOAD     = 3'd1,
    ACT_SET_D2   = 3'd2,
    ACT_DIV_INIT = 3'd3,
    ACT_DIV_STEP = 3'd4,
    ACT_INC_D    = 3'd5,
    ACT_SET_FLAG = 3'd6,
    ACT_EMIT     = 3'd7
  } act_t;

  // Jump condition: taken -> target, else fall through to the next step
  typedef enum logic [2:0] {
    CND_NEVER    = 3'd0,
    CND_ALWAYS   = 3'd1,
    CND_NO_XFER  = 3'd2,
    CND_N_LT2    = 3'd3,
    CND_DIV_BUSY = 3'd4,
    CND_D_GT_Q   = 3'd5,
    CND_R_ZERO   = 3'd6,
    CND_OUT_BUSY = 3'd7
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  // Microprogram read-only table
  function automatic ctrl_word_t ucode_rom(input step_t step);
    ctrl_word_t w;
    unique case (step)
      STEP_WAIT:    w = '{act: ACT_LOAD,     cond: CND_NO_XFER,  target: STEP_WAIT};
      STEP_SMALL:   w = '{act: ACT_SET_D2,   cond: CND_N_LT2,    target: STEP_EMIT};
      STEP_DIVINIT: w = '{act: ACT_DIV_INIT, cond: CND_NEVER,    target: STEP_WAIT};
      STEP_DIVSTEP: w = '{act: ACT_DIV_STEP, cond: CND_DIV_BUSY, target: STEP_DIVSTEP};
      STEP_TEST_Q:  w = '{act: ACT_NOP,      cond: CND_D_GT_Q,   target: STEP_PRIME};
      STEP_TEST_R:  w = '{act: ACT_NOP,      cond: CND_R_ZERO,   target: STEP_EMIT};
      STEP_NEXT:    w = '{act: ACT_INC_D,    cond: CND_ALWAYS,   target: STEP_DIVINIT};
      STEP_PRIME:   w = '{act: ACT_SET_FLAG, cond: CND_NEVER,    target: STEP_WAIT};
      STEP_EMIT:    w = '{act: ACT_EMIT,     cond: CND_OUT_BUSY, target: STEP_EMIT};
      STEP_DONE:    w = '{act: ACT_NOP,      cond: CND_ALWAYS,   target: STEP_WAIT};
      default:      w = '{act: ACT_NOP,      cond: CND_ALWAYS,   target: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

/* rtl/tdp_ifs.sv */
`timescale 1ns / 1ps

interface tdp_in_if;
  logic                          valid;
  logic                          ready;
  logic [tdp_pkg::VALUE_BITS-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface tdp_out_if;
  logic valid;
  logic ready;
  logic prime_flag;

  modport source (output valid, output prime_flag, input ready);
  modport sink   (input valid, input prime_flag, output ready);
endinterface

/* rtl/trial_division_prime_test.sv */
`timescale 1ns / 1ps

// Channel   Dir  Payload                         Handshake
// in_ch     in   candidate  [VALUE_BITS-1:0]     valid/ready, transfer when both high
// out_ch    out  prime_flag [0]                  valid/ready, transfer when both high
//
// Flow: one item at a time. A candidate below 2 goes from the small-candidate check
// straight to the emit step, then through the done step back to the wait step for input.
// Any other candidate runs one division plus the test steps per tried divisor (bit-serial
// restoring divider, one quotient bit per cycle), divisors 2 up to about
// sqrt(candidate): worst case near 46341 tried divisors. Reset: synchronous, active low;
// clears the step counter and any pending result. Stalls: the output register frees
// the program for the next candidate; it holds at the emit step only behind a result.

module trial_division_prime_test (
  input  logic             clk,
  input  logic             rst_n,
  tdp_in_if.sink           in_ch,
  tdp_out_if.source        out_ch
);

  localparam int W = tdp_pkg::VALUE_BITS;

  // Sequencer
  tdp_pkg::step_t      pc_r, pc_nxt;
  tdp_pkg::ctrl_word_t ctrl;
  logic                jump;

  // Datapath
  logic [W-1:0]              n_r, n_nxt;
  logic [W-1:0]              d_r, d_nxt;
  logic [W-1:0]              rem_r, rem_nxt;
  logic [W-1:0]              quo_r, quo_nxt;
  logic [tdp_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      flag_r, flag_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_flag_r, out_flag_nxt;

  logic         in_xfer;
  logic         out_free;
  logic         cnt_last;
  logic [W:0]   rem_shift;
  logic [W:0]   rem_diff;
  logic         rem_ge;

  assign ctrl      = tdp_pkg::ucode_rom(pc_r);
  // Ready comes straight from the microcode: only the load step takes input.
  assign in_ch.ready = (ctrl.act == tdp_pkg::ACT_LOAD);
  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign cnt_last  = (cnt_r == tdp_pkg::CNT_W'(W - 1));

  // One restoring-division step: shift in the next dividend bit, try subtract.
  assign rem_shift = {rem_r, quo_r[W-1]};
  assign rem_diff  = rem_shift - {1'b0, d_r};
  assign rem_ge    = !rem_diff[W];

  // Jump condition decode
  always_comb begin
    unique case (ctrl.cond)
      tdp_pkg::CND_NEVER:    jump = 1'b0;
      tdp_pkg::CND_ALWAYS:   jump = 1'b1;
      tdp_pkg::CND_NO_XFER:  jump = !in_xfer;
      tdp_pkg::CND_N_LT2:    jump = (n_r < W'(2));
      tdp_pkg::CND_DIV_BUSY: jump = !cnt_last;
      tdp_pkg::CND_D_GT_Q:   jump = (d_r > quo_r);
      tdp_pkg::CND_R_ZERO:   jump = (rem_r == '0);
      tdp_pkg::CND_OUT_BUSY: jump = !out_free;
      default:               jump = 1'b0;
    endcase
  end

  // Next step and datapath actions
  always_comb begin
    pc_nxt        = jump ? ctrl.target : tdp_pkg::step_t'(pc_r + 4'd1);
    n_nxt         = n_r;
    d_nxt         = d_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    flag_nxt      = flag_r;
    out_flag_nxt  = out_flag_r;
    // Drop the result once the sink takes it.
    out_valid_nxt = out_valid_r && !out_ch.ready;

    unique case (ctrl.act)
      tdp_pkg::ACT_NOP: begin
      end
      tdp_pkg::ACT_LOAD: begin
        if (in_xfer) n_nxt = in_ch.candidate;
      end
      tdp_pkg::ACT_SET_D2: begin
        d_nxt    = W'(2);
        flag_nxt = 1'b0;
      end
      tdp_pkg::ACT_DIV_INIT: begin
        rem_nxt = '0;
        quo_nxt = n_r;
        cnt_nxt = '0;
      end
      tdp_pkg::ACT_DIV_STEP: begin
        rem_nxt = rem_ge ? rem_diff[W-1:0] : rem_shift[W-1:0];
        quo_nxt = {quo_r[W-2:0], rem_ge};
        cnt_nxt = cnt_r + 1'b1;
      end
      tdp_pkg::ACT_INC_D: begin
        d_nxt = d_r + 1'b1;
      end
      tdp_pkg::ACT_SET_FLAG: begin
        flag_nxt = 1'b1;
      end
      tdp_pkg::ACT_EMIT: begin
        // Hold here until the output register is free, then load it.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_flag_nxt  = flag_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= tdp_pkg::STEP_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    d_r        <= d_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    flag_r     <= flag_nxt;
    out_flag_r <= out_flag_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.prime_flag = out_flag_r;

  // A transfer always starts the program at the small-candidate check.
  a_start_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (pc_r == tdp_pkg::STEP_SMALL))
    else $error("program did not start after input transfer");

  // The divider leaves a remainder below the divisor.
  a_rem_below_d: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == tdp_pkg::STEP_TEST_Q) |-> (rem_r < d_r))
    else $error("remainder not below divisor after division");

  // The bit counter never runs past the last dividend bit.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == tdp_pkg::STEP_DIVSTEP) |-> (cnt_r <= tdp_pkg::CNT_W'(W - 1)))
    else $error("divider bit counter out of range");

  // A prime verdict is never given for a candidate below two.
  a_flag_small: assert property (@(posedge clk) disable iff (!rst_n)
    ((pc_r == tdp_pkg::STEP_EMIT) && flag_r) |-> (n_r >= W'(2)))
    else $error("prime flag set for candidate below two");

endmodule

/* dv/trial_division_prime_test_tb.sv */
`timescale 1ns / 1ps

module trial_division_prime_test_tb;

  localparam int VALUE_BITS = tdp_pkg::VALUE_BITS;
  localparam longint unsigned MAX_CAND = (64'd1 << VALUE_BITS) - 1;

  // One candidate waiting to go out, with the idle gap that follows its transfer.
  // A drain item is held back until every earlier result has come home.
  typedef struct {
    logic [VALUE_BITS-1:0] cand;
    int unsigned           gap;
    bit                    drain;
  } cand_item_t;

  // One predicted verdict, kept with its candidate for the mismatch report
  typedef struct {
    logic [VALUE_BITS-1:0] cand;
    bit                    flag;
  } verdict_t;

  logic clk;
  logic rst_n;

  tdp_in_if  in_if ();
  tdp_out_if out_if ();

  trial_division_prime_test uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  cand_item_t      cand_q[$];
  verdict_t        verdict_q[$];
  int unsigned     sent_count   = 0;
  int unsigned     done_count   = 0;
  int unsigned     gap_left     = 0;
  int unsigned     stall_left   = 0;
  int unsigned     errors       = 0;
  longint unsigned cycle_count  = 0;
  longint unsigned cycle_limit  = 0;
  longint unsigned cycle_budget = 0;

  // Decide primality by trial division, stopping once the divisor passes the
  // integer square root. Also report how many divisors were tried, so the
  // stimulus can estimate how long the block needs for this candidate.
  function automatic bit predict_prime(input logic [VALUE_BITS-1:0] cand,
                                       output int unsigned tries);
    longint unsigned n;
    longint unsigned d;
    n = 64'(cand);
    tries = 0;
    if (n < 2) return 1'b0;
    for (d = 2; d <= n / d; d++) begin
      tries++;
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Queue one candidate and grow the time allowance by its worst case:
  // every tried divisor costs one bit-serial division plus the test steps,
  // then the sender gap, a long receiver stall and some slack.
  task automatic add_cand(input logic [VALUE_BITS-1:0] cand, input int unsigned gap,
                          input bit drain);
    int unsigned tries;
    bit          unused_flag;
    unused_flag = predict_prime(cand, tries);
    cand_q.push_back('{cand: cand, gap: gap, drain: drain});
    cycle_budget += longint'(tries + 2) * (VALUE_BITS + 6) + gap + 300;
  endtask

  // Free-running clock, 12 ns period
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hold reset low at the start of the run, once
  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Stimulus and end of run
  initial begin
    int unsigned r;
    int unsigned gap;
    int unsigned p;
    logic [VALUE_BITS-1:0] cand;
    int unsigned primes_small[5];

    primes_small = '{3, 5, 7, 11, 13};

    // Directed part, mostly back to back: below two, the two smallest primes that
    // skip every divisor, small composites, squares of primes that end right
    // on the square-root boundary, powers of two, and the field extremes
    // including the all-ones value, which is prime and the slowest case.
    add_cand(0, 0, 1'b0);
    add_cand(1, 0, 1'b0);
    add_cand(2, 0, 1'b0);
    add_cand(3, 0, 1'b0);
    add_cand(4, 0, 1'b0);
    add_cand(5, 0, 1'b0);
    add_cand(6, 0, 1'b0);
    add_cand(7, 0, 1'b0);
    add_cand(8, 0, 1'b0);
    add_cand(9, 1, 1'b0);
    add_cand(25, 0, 1'b0);
    add_cand(49, 2, 1'b0);
    add_cand(961, 0, 1'b0);
    add_cand(65521, 0, 1'b0);
    add_cand(65536, 0, 1'b0);
    add_cand(65537, 3, 1'b0);
    add_cand(16777213, 0, 1'b0);
    add_cand(31'h4000_0000, 0, 1'b0);
    add_cand(31'h5555_5555, 0, 1'b0);
    add_cand(31'h2AAA_AAAA, 0, 1'b0);
    add_cand(VALUE_BITS'(MAX_CAND - 1), 0, 1'b0);
    add_cand(VALUE_BITS'(MAX_CAND), 0, 1'b0);

    // Random part: mostly small candidates so divisor loops stay short,
    // some medium ones, and full-width values that fall to a small factor
    // so every bit of the field toggles without the worst-case runtime.
    for (int i = 0; i < 78; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        cand = VALUE_BITS'($urandom_range(0, 4095));
      end else if (r < 75) begin
        cand = VALUE_BITS'($urandom_range(0, 262143));
      end else if (r < 88) begin
        cand    = VALUE_BITS'($urandom);
        cand[0] = 1'b0;
      end else begin
        p    = primes_small[$urandom_range(0, 4)];
        cand = VALUE_BITS'($urandom_range(0, int'(MAX_CAND / p)) * p);
      end
      r = $urandom_range(0, 99);
      if (r < 40)      gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else             gap = $urandom_range(10, 100);
      // Drain the pipe before the first random item and now and then later
      add_cand(cand, gap, (i == 0) || ($urandom_range(0, 29) == 0));
    end

    cycle_limit = 3 * cycle_budget + 20000;

    // Wait for every candidate to transfer and every verdict to return,
    // then give the block a short tail to show any stray result.
    while (cand_q.size() != 0 || in_if.valid || sent_count != done_count)
      @(posedge clk);
    repeat (60) @(posedge clk);
    if (verdict_q.size() != 0) begin
      $display("%0t: missing result for candidate %0d: expected %0b, actual none",
               $time, verdict_q[0].cand, verdict_q[0].flag);
    end

    if (errors == 0 && verdict_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Cycle watchdog; the limit follows from the queued stimulus
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_limit != 0 && cycle_count > cycle_limit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Driver: on each transfer, predict the verdict for the candidate that
  // moved; then hold a stalled candidate, count down a gap, or present the
  // next one. A drain item waits until sent and returned counts agree.
  always @(posedge clk) begin : drive_proc
    bit          took;
    bit          flag;
    int unsigned tries;
    cand_item_t  item;
    took = in_if.valid && in_if.ready;
    if (!rst_n) begin
      in_if.valid     <= 1'b0;
      in_if.candidate <= '0;
      gap_left        <= 0;
    end else begin
      if (took) begin
        flag = predict_prime(in_if.candidate, tries);
        verdict_q.push_back('{cand: in_if.candidate, flag: flag});
        sent_count <= sent_count + 1;
      end
      if (in_if.valid && !took) begin
        // hold the candidate until the block takes it
      end else if (gap_left != 0) begin
        in_if.valid <= 1'b0;
        gap_left    <= gap_left - 1;
      end else if (cand_q.size() != 0 &&
                   !(cand_q[0].drain && sent_count + took != done_count)) begin
        item = cand_q.pop_front();
        in_if.valid     <= 1'b1;
        in_if.candidate <= item.cand;
        gap_left        <= item.gap;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each returned flag with the oldest prediction, and
  // drop ready at random. No stall starts in the first quarter of each
  // cycle_count % 4096 window; else mostly short stalls with a few long ones.
  always @(posedge clk) begin : sink_proc
    verdict_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        done_count <= done_count + 1;
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: result with no candidate pending: prime_flag %0b",
                   $time, out_if.prime_flag);
        end else begin
          want = verdict_q.pop_front();
          if (out_if.prime_flag !== want.flag) begin
            errors++;
            $display("%0t: prime_flag mismatch for candidate %0d: expected %0b, actual %0b",
                     $time, want.cand, want.flag, out_if.prime_flag);
          end
        end
      end
      if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else if (cycle_count % 4096 >= 1024 && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        stall_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                                    : $urandom_range(0, 3);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

endmodule
